@@ hw/rtl/slfr_pkg.sv @@
// ----------------------------------------------------------------------------
// slfr_pkg - shared types and constants of the sync/length frame receiver
// Result kinds, frame position codes, register indexes and the structs that
// pass between the receiver's sub-blocks.
// ----------------------------------------------------------------------------
package slfr_pkg;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_BAD     = 2'd2
	} kind_t;

	typedef enum logic {
		CFG_SYNC_VALUE = 1'b0,
		CFG_MAX_LENGTH = 1'b1
	} cfg_index_t;

	localparam logic [7:0] SYNC_RESET   = 8'h55;
	localparam logic [7:0] MAXLEN_RESET = 8'd100;
	localparam logic [7:0] MIN_LENGTH   = 8'd4;

	// frame position codes; after the command byte the position is the byte index
	localparam logic [7:0] POS_HUNT       = 8'd0;
	localparam logic [7:0] POS_LENGTH     = 8'd1;
	localparam logic [7:0] POS_COMMAND    = 8'd2;

	typedef struct packed {
		logic [7:0] sync_value;
		logic [7:0] max_length;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] rx_byte;
	} word_t;

endpackage

@@ hw/rtl/slfr_if.sv @@
// ----------------------------------------------------------------------------
// slfr_in_if / slfr_out_if - valid/ready channels of the frame receiver
// Input carries one received byte per word; output carries one frame event.
// ----------------------------------------------------------------------------
interface slfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slfr_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] byte_value;
	logic [7:0] byte_index;
	logic [7:0] command_code;
	logic [7:0] frame_length;

	modport source (output valid, output kind, output byte_value, output byte_index,
		output command_code, output frame_length, input ready);
	modport sink   (input valid, input kind, input byte_value, input byte_index,
		input command_code, input frame_length, output ready);
endinterface

@@ hw/rtl/sync_length_frame_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// sync_length_frame_receiver_unit - length-prefixed frame receiver, XOR check
// Hunts for the sync byte, checks the length byte against 4..max_length,
// keeps the command byte, passes payload bytes on with their index and
// reports the frame as good or bad when the checksum byte arrives.
// ----------------------------------------------------------------------------
//
//  channel  dir  word                                         handshake
//  -------  ---  -------------------------------------------  -----------
//  rx       in   rx_byte                                      valid/ready
//  res      out  kind, byte_value, byte_index, command_code,  valid/ready
//                frame_length
//  cfg      in   cfg_index, cfg_data                          cfg_we only
//
//  One byte word accepted per cycle, sustained while res is not stalled.
//  A result is built from a registered byte: the accepting edge loads the input
//  register, the parser logic then loads the result register once take is high.
//  Sync, length and command bytes and rejected lengths give no result word.
//  A stall on res holds the result register; the input register can still
//  take one byte while empty, and rx.ready stays low while it is full.
//  Reset clears the frame state to hunting and both pipeline valids; the
//  registers return to sync 0x55 and max_length 100.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver_unit (
	input  logic        clk,
	input  logic        arst_n,
	slfr_in_if.sink     rx,
	slfr_out_if.source  res,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	import slfr_pkg::*;

	cfg_t  cfg;    // live register values
	word_t word;   // registered byte on its way to the parser
	logic  take;   // parser can consume the held byte this cycle

	slfr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	slfr_in_stage u_in (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.take   (take),
		.word   (word)
	);

	// frame tracking, running XOR and the output register
	slfr_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.word   (word),
		.take   (take),
		.res    (res)
	);

endmodule

@@ hw/rtl/slfr_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// slfr_cfg_regs - configuration registers
// Holds the sync byte value and the maximum accepted frame length.
// ----------------------------------------------------------------------------
module slfr_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data,
	output slfr_pkg::cfg_t      cfg
);
	import slfr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_value <= SYNC_RESET;
			cfg_q.max_length <= MAXLEN_RESET;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_SYNC_VALUE: cfg_q.sync_value <= cfg_data;
				CFG_MAX_LENGTH: cfg_q.max_length <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/slfr_in_stage.sv @@
// ----------------------------------------------------------------------------
// slfr_in_stage - input register
// Captures one received byte per cycle; holds it while the parser stalls.
// ----------------------------------------------------------------------------
module slfr_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	slfr_in_if.sink         rx,
	input  logic            take,
	output slfr_pkg::word_t word
);
	import slfr_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       load;

	assign rx.ready = !valid_s1 || take;
	assign load     = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign word.valid   = valid_s1;
	assign word.rx_byte = byte_s1;

endmodule

@@ hw/rtl/slfr_parser.sv @@
// ----------------------------------------------------------------------------
// slfr_parser - frame state and result register
// Tracks the frame position, length, command and running XOR, and loads one
// result word per payload or checksum byte.
// ----------------------------------------------------------------------------
module slfr_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  slfr_pkg::cfg_t  cfg,
	input  slfr_pkg::word_t word,
	output logic            take,
	slfr_out_if.source      res
);
	import slfr_pkg::*;

	logic [7:0] pos_q, len_q, xor_q, cmd_q;
	logic [7:0] pos_d, len_d, xor_d, cmd_d;
	logic       advance, emit, last;
	kind_t      kind_d;

	logic       res_valid_q;
	kind_t      kind_q;
	logic [7:0] value_q, index_q, cmd_res_q, len_res_q;

	assign take    = !res_valid_q || res.ready;
	assign advance = word.valid && take;
	assign last    = ({1'b0, pos_q} + 9'd1) >= {1'b0, len_q};

	always_comb begin
		pos_d  = pos_q;
		len_d  = len_q;
		xor_d  = xor_q;
		cmd_d  = cmd_q;
		emit   = 1'b0;
		kind_d = KIND_PAYLOAD;
		if (advance) begin
			if (pos_q == POS_HUNT) begin
				if (word.rx_byte == cfg.sync_value) begin
					xor_d = word.rx_byte;
					pos_d = POS_LENGTH;
				end
			end else if (pos_q == POS_LENGTH) begin
				if (word.rx_byte < MIN_LENGTH || word.rx_byte > cfg.max_length) begin
					pos_d = POS_HUNT;
					xor_d = 8'd0;
				end else begin
					len_d = word.rx_byte;
					xor_d = xor_q ^ word.rx_byte;
					pos_d = POS_COMMAND;
				end
			end else if (pos_q == POS_COMMAND) begin
				cmd_d = word.rx_byte;
				xor_d = xor_q ^ word.rx_byte;
				pos_d = pos_q + 8'd1;
			end else if (last) begin
				emit   = 1'b1;
				kind_d = (word.rx_byte == xor_q) ? KIND_GOOD : KIND_BAD;
				pos_d  = POS_HUNT;
				xor_d  = 8'd0;
			end else begin
				emit  = 1'b1;
				xor_d = xor_q ^ word.rx_byte;
				pos_d = pos_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_HUNT;
			len_q       <= 8'd0;
			xor_q       <= 8'd0;
			cmd_q       <= 8'd0;
			res_valid_q <= 1'b0;
		end else begin
			pos_q <= pos_d;
			len_q <= len_d;
			xor_q <= xor_d;
			cmd_q <= cmd_d;
			if (take) begin
				res_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q    <= kind_d;
			value_q   <= word.rx_byte;
			index_q   <= pos_q;
			cmd_res_q <= cmd_q;
			len_res_q <= len_q;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.kind         = kind_q;
	assign res.byte_value   = value_q;
	assign res.byte_index   = index_q;
	assign res.command_code = cmd_res_q;
	assign res.frame_length = len_res_q;

endmodule

@@ hw/rtl/slfr_checker.sv @@
// ----------------------------------------------------------------------------
// slfr_checker - port-level checks on the frame receiver
// Watches the result channel for stall hold, frame length and frame-position consistency.
// ----------------------------------------------------------------------------
module slfr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] res_kind,
	input logic [7:0] res_byte_index,
	input logic [7:0] res_frame_length
);
	import slfr_pkg::*;

	logic [8:0] idx_next;
	assign idx_next = {1'b0, res_byte_index} + 9'd1;

	// stalled result word is not dropped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped under stall");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_frame_length >= MIN_LENGTH)
		else $error("frame length below minimum");

	// payload sits after the command byte and before the checksum
	a_payload_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == KIND_PAYLOAD |->
			res_byte_index > POS_COMMAND && idx_next < {1'b0, res_frame_length})
		else $error("payload byte index out of frame");

	a_end_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == KIND_GOOD || res_kind == KIND_BAD) |->
			idx_next == {1'b0, res_frame_length})
		else $error("checksum byte not at frame end");

endmodule

bind sync_length_frame_receiver_unit slfr_checker u_slfr_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_kind         (res.kind),
	.res_byte_index   (res.byte_index),
	.res_frame_length (res.frame_length)
);

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb - testbench of sync_length_frame_receiver_unit
// Feeds received bytes through the rx channel and tracks the frame parser in
// a model of its own, so every result word is compared field by field with
// the event the model expects. Directed frames come first, then random
// traffic under several register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb;
	import slfr_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 4;	// input reg + result reg, with margin
	localparam int RANDOM_WORDS = 380;	// per random phase
	localparam int HOLD_CYCLES  = 200;

	// one expected frame event, laid out like the res word
	typedef struct packed {
		kind_t      kind;
		logic [7:0] byte_value;
		logic [7:0] byte_index;
		logic [7:0] command_code;
		logic [7:0] frame_length;
	} frame_event_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_data;

	slfr_in_if  rx ();
	slfr_out_if res ();

	sync_length_frame_receiver_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// register shadows and parser state of the frame model
	logic [7:0] cur_sync;
	logic [7:0] cur_max;
	logic [7:0] rx_pos;
	logic [7:0] rx_len;
	logic [7:0] rx_xor;
	logic [7:0] rx_cmd;

	frame_event_t pending_events[$];

	int mismatches;
	int words_sent;
	int cycles;
	int send_idle_pct;	// chance per cycle that the sender holds back
	int stall_pct;		// chance per cycle that the receiver stalls
	int hold_req;		// long receiver hold-off, picked up by the ready process

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog: a hung handshake or a lost result word ends here
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver side: random stalls, or a long hold-off when asked for one
	always @(posedge clk) begin : drive_ready
		int hold_left;
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// every word taken from res must match the oldest expected event
	always @(posedge clk) begin : check_results
		frame_event_t want;
		if (arst_n && res.valid && res.ready) begin
			if (pending_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: kind %0d value %h index %0d cmd %h len %0d",
						res.kind, res.byte_value, res.byte_index, res.command_code,
						res.frame_length);
			end else begin
				want = pending_events.pop_front();
				if (res.kind !== want.kind || res.byte_value !== want.byte_value ||
					res.byte_index !== want.byte_index ||
					res.command_code !== want.command_code ||
					res.frame_length !== want.frame_length) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: want kind %0d value %h index %0d cmd %h len %0d",
							want.kind, want.byte_value, want.byte_index, want.command_code,
							want.frame_length);
						$display("           got kind %0d value %h index %0d cmd %h len %0d",
							res.kind, res.byte_value, res.byte_index,
							res.command_code, res.frame_length);
					end
				end
			end
		end
	end

	// frame model: advances on each accepted byte and queues the event it gives
	task automatic track_byte(input logic [7:0] b);
		frame_event_t ev;
		if (rx_pos == POS_HUNT) begin
			if (b == cur_sync) begin
				rx_xor = b;
				rx_pos = POS_LENGTH;
			end
		end else if (rx_pos == POS_LENGTH) begin
			// a rejected length is not looked at again as a sync byte
			if (b < MIN_LENGTH || b > cur_max) begin
				rx_pos = POS_HUNT;
				rx_xor = '0;
			end else begin
				rx_len = b;
				rx_xor ^= b;
				rx_pos = POS_COMMAND;
			end
		end else if (rx_pos == POS_COMMAND) begin
			rx_cmd = b;
			rx_xor ^= b;
			rx_pos = POS_COMMAND + 8'd1;
		end else begin
			ev.byte_value   = b;
			ev.byte_index   = rx_pos;
			ev.command_code = rx_cmd;
			ev.frame_length = rx_len;
			if (int'(rx_pos) + 1 >= int'(rx_len)) begin
				// last byte of the frame is the checksum
				ev.kind = (b == rx_xor) ? KIND_GOOD : KIND_BAD;
				rx_pos = POS_HUNT;
				rx_xor = '0;
			end else begin
				ev.kind = KIND_PAYLOAD;
				rx_xor ^= b;
				rx_pos++;
			end
			pending_events.push_back(ev);
		end
	endtask

	// offer one byte word; valid stays high afterwards unless a gap follows
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			rx.valid <= 1'b0;
			@(posedge clk);
		end
		rx.valid   <= 1'b1;
		rx.rx_byte <= b;
		do @(posedge clk); while (!rx.ready);
		words_sent++;
		track_byte(b);
	endtask

	// sync, length, command, payload and checksum; stops after 'upto' bytes
	task automatic send_frame(input int len, input logic [7:0] code, input bit corrupt,
		input int upto);
		logic [7:0] sum;
		logic [7:0] b;
		sum = cur_sync ^ 8'(len) ^ code;
		send_byte(cur_sync);
		send_byte(8'(len));
		send_byte(code);
		for (int i = 3; i < upto; i++) begin
			if (i == len - 1) begin
				b = corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum;
			end else begin
				b = 8'($urandom);
				sum ^= b;
			end
			send_byte(b);
		end
	endtask

	// stop sending and wait until every expected word has come out
	task automatic settle();
		rx.valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// both registers, back to back; only called with the block idle
	task automatic write_regs(input logic [7:0] sync_b, input logic [7:0] max_b);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SYNC_VALUE;
		cfg_data  <= sync_b;
		@(posedge clk);
		cur_sync = sync_b;
		cfg_index <= CFG_MAX_LENGTH;
		cfg_data  <= max_b;
		@(posedge clk);
		cur_max = max_b;
		cfg_we <= 1'b0;
	endtask

	// reset settings: noise, both length rejections, shortest frame, bad checksum
	task automatic test_reset_defaults();
		send_idle_pct = 0;
		stall_pct     = 0;
		send_byte(8'h00);
		send_byte(SYNC_RESET);
		send_byte(8'd3);
		send_byte(SYNC_RESET);
		send_byte(8'd101);
		send_frame(4, 8'hFF, 1'b0, 4);
		send_frame(5, 8'h00, 1'b1, 5);
		send_frame(6, 8'h12, 1'b0, 6);
		settle();
	endtask

	// register extremes: sync 0 and 255, max_length 4, below 4, and 255
	task automatic test_register_extremes();
		write_regs(8'h00, MIN_LENGTH);
		// sync, rejected zero length, then bytes that must all be ignored
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h04);
		send_byte(8'h11);
		send_byte(8'h22);
		send_frame(4, 8'h00, 1'b0, 4);
		send_byte(8'h00);
		send_byte(8'h05);
		send_frame(4, 8'hFF, 1'b1, 4);
		settle();

		// max_length below the minimum: nothing gets past the length byte
		write_regs(8'h00, 8'd3);
		send_byte(8'h00);
		send_byte(8'h04);
		send_byte(8'h00);
		send_byte(8'h03);
		send_byte(8'h00);
		send_byte(8'h00);
		settle();
		write_regs(8'h00, 8'h00);
		send_byte(8'h00);
		send_byte(8'h04);
		settle();

		// longest frame: indexes run up to 254
		write_regs(8'hFF, 8'hFF);
		send_frame(255, 8'hA5, 1'b0, 255);
		send_frame(4, 8'h00, 1'b0, 4);
		settle();
	endtask

	// hold res off for a long stretch while rx keeps offering bytes
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_req      = HOLD_CYCLES;
		send_frame(60, 8'h3C, 1'b0, 60);
		send_frame(5, 8'hC3, 1'b1, 5);
		settle();
	endtask

	// mostly whole frames with random content, plus noise and broken frames
	task automatic test_random_traffic(input logic [7:0] sync_b, input logic [7:0] max_b,
		input int idle_pct, input int stall_b, input int words);
		int first;
		int pick;
		int len;
		int top;
		logic [7:0] bad;
		write_regs(sync_b, max_b);
		send_idle_pct = idle_pct;
		stall_pct     = stall_b;
		first         = words_sent;
		top           = (cur_max < 8'd20) ? int'(cur_max) : 20;
		while (words_sent - first < words) begin
			pick = $urandom_range(99);
			if ($urandom_range(99) < 2)
				len = cur_max;
			else
				len = $urandom_range(4, top);
			if (pick < 70) begin
				send_frame(len, 8'($urandom), 1'b0, len);
			end else if (pick < 78) begin
				send_frame(len, 8'($urandom), 1'b1, len);
			end else if (pick < 88) begin
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
			end else if (pick < 95) begin
				// length out of range, low or high
				if (cur_max == 8'hFF || $urandom_range(1) == 0)
					bad = 8'($urandom_range(0, 3));
				else
					bad = 8'($urandom_range(int'(cur_max) + 1, 255));
				send_byte(cur_sync);
				send_byte(bad);
			end else begin
				// cut short; what follows lands inside this frame
				send_frame(len, 8'($urandom), 1'b0, $urandom_range(3, len - 1));
			end
		end
		settle();
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_SYNC_VALUE;
		cfg_data   = '0;
		rx.valid   = 1'b0;
		rx.rx_byte = '0;
		res.ready  = 1'b0;

		cur_sync = SYNC_RESET;
		cur_max  = MAXLEN_RESET;
		rx_pos   = POS_HUNT;
		rx_len   = '0;
		rx_xor   = '0;
		rx_cmd   = '0;

		mismatches    = 0;
		words_sent    = 0;
		cycles        = 0;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_req      = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_output_backpressure();
		// idling phases: none, sender sparse, receiver stalling, both
		test_random_traffic(8'hA5, 8'hFF, 0, 0, RANDOM_WORDS);
		test_random_traffic(8'h00, 8'd12, 88, 0, RANDOM_WORDS);
		test_random_traffic(8'hFF, MIN_LENGTH, 0, 88, RANDOM_WORDS);
		test_random_traffic(8'($urandom), 8'($urandom_range(4, 255)), 32, 32, RANDOM_WORDS);

		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/slfr_pkg.sv
hw/rtl/slfr_if.sv
hw/rtl/slfr_cfg_regs.sv
hw/rtl/slfr_in_stage.sv
hw/rtl/slfr_parser.sv
hw/rtl/sync_length_frame_receiver_unit.sv
hw/rtl/slfr_checker.sv
sim/tb.sv
